// File: hdl/swd_pkg.sv
// ----------------------------------------------------------------------------
// SWD host package
// Shared types and constants for the serial wire debug host bit engine.
// ----------------------------------------------------------------------------
package swd_pkg;

  localparam int unsigned OP_W         = 2;
  localparam int unsigned CNT_W        = 6;
  localparam int unsigned DATA_W       = 32;
  localparam int unsigned SAMP_W       = 33;
  localparam int unsigned CFG_W        = 16;
  localparam int unsigned TMR_W        = CFG_W + 1;
  localparam int unsigned MAX_BITS_DEF = 32;

  localparam int unsigned OP_READ_BIT  = 1;
  localparam int unsigned OP_PAR_BIT   = 0;

  typedef enum logic [1:0] {
    KIND_TURN,
    KIND_DATA,
    KIND_PAR
  } swd_kind_e;

  typedef struct packed {
    logic      load;
    logic      emit;
    swd_kind_e kind;
    logic      last;
  } swd_cmd_t;

  typedef struct packed {
    logic timer_done;
    logic is_read;
    logic with_par;
    logic cnt_zero;
    logic cnt_one;
  } swd_sts_t;

endpackage

// File: hdl/swd_req_if.sv
// ----------------------------------------------------------------------------
// SWD request channel
// Valid/ready channel that carries one bit-shift request.
// ----------------------------------------------------------------------------
interface swd_req_if
  import swd_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     op;
  logic [CNT_W-1:0]    bit_count;
  logic [DATA_W-1:0]   out_data;
  logic [SAMP_W-1:0]   line_samples;

  modport source (output valid, output op, output bit_count, output out_data,
                  output line_samples, input ready);
  modport sink (input valid, input op, input bit_count, input out_data,
                input line_samples, output ready);
endinterface

// File: hdl/swd_rsp_if.sv
// ----------------------------------------------------------------------------
// SWD result channel
// Valid/ready channel that carries one SWCLK period of line activity.
// ----------------------------------------------------------------------------
interface swd_rsp_if
  import swd_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic              swdio_level;
  logic              swdio_enable;
  logic [DATA_W-1:0] read_data;
  logic              parity_ok;
  logic              last;

  modport source (output valid, output swdio_level, output swdio_enable,
                  output read_data, output parity_ok, output last, input ready);
  modport sink (input valid, input swdio_level, input swdio_enable,
                input read_data, input parity_ok, input last, output ready);
endinterface

// File: hdl/swd_dp.sv
// ----------------------------------------------------------------------------
// SWD datapath
// Holds the request, shifts write data, assembles the read word, checks
// parity, times each SWCLK period and registers the outgoing period.
// ----------------------------------------------------------------------------
module swd_dp
  import swd_pkg::*;
#(
  parameter int unsigned MaxBits = MAX_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CFG_W-1:0]  cfg_wdata_i,
  input  logic [OP_W-1:0]   op_i,
  input  logic [CNT_W-1:0]  bit_count_i,
  input  logic [DATA_W-1:0] out_data_i,
  input  logic [SAMP_W-1:0] line_samples_i,
  input  swd_cmd_t          cmd_i,
  output swd_sts_t          sts_o,
  output logic              swdio_level_o,
  output logic              swdio_enable_o,
  output logic [DATA_W-1:0] read_data_o,
  output logic              parity_ok_o,
  output logic              last_o
);

  localparam logic [CNT_W-1:0] MaxCnt = CNT_W'(MaxBits);

  logic [CFG_W-1:0]  hpw_q;
  logic [TMR_W-1:0]  tmr_q, tmr_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              is_read_q, with_par_q;
  logic [DATA_W-1:0] wdata_q, wdata_d;
  logic [DATA_W-1:0] rd_word_q;
  logic              ok_q, wpar_q;
  logic              level_q, en_q, pok_q, last_q;
  logic [DATA_W-1:0] rdata_q;

  logic [CNT_W-1:0]  n_sat;
  logic [DATA_W:0]   mask_w;
  logic [DATA_W-1:0] word_w;
  logic              par_smp;
  logic              level_w, en_w;

  always_comb begin
    n_sat   = (bit_count_i > MaxCnt) ? MaxCnt : bit_count_i;
    mask_w  = {(DATA_W + 1){1'b1}} << n_sat;
    word_w  = line_samples_i[DATA_W-1:0] & ~mask_w[DATA_W-1:0];
    par_smp = line_samples_i[n_sat];
  end

  always_comb begin
    tmr_d   = tmr_q;
    cnt_d   = cnt_q;
    wdata_d = wdata_q;
    if (cmd_i.load) begin
      cnt_d   = n_sat;
      wdata_d = out_data_i;
    end else if (cmd_i.emit && cmd_i.kind == KIND_DATA) begin
      cnt_d   = cnt_q - CNT_W'(1);
      wdata_d = wdata_q >> 1;
    end
    if (cmd_i.emit) begin
      tmr_d = {hpw_q, 1'b0};
    end else if (tmr_q != '0) begin
      tmr_d = tmr_q - TMR_W'(1);
    end
  end

  always_comb begin
    level_w = 1'b0;
    en_w    = 1'b0;
    case (cmd_i.kind)
      KIND_DATA: begin
        en_w    = ~is_read_q;
        level_w = ~is_read_q & wdata_q[0];
      end
      KIND_PAR: begin
        en_w    = ~is_read_q;
        level_w = ~is_read_q & wpar_q;
      end
      default: begin
        en_w    = 1'b0;
        level_w = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hpw_q <= '0;
      tmr_q <= '0;
      cnt_q <= '0;
    end else begin
      if (cfg_we_i) begin
        hpw_q <= cfg_wdata_i;
      end
      tmr_q <= tmr_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wdata_q <= wdata_d;
    if (cmd_i.load) begin
      is_read_q  <= op_i[OP_READ_BIT];
      with_par_q <= op_i[OP_PAR_BIT];
      rd_word_q  <= word_w;
      ok_q       <= (par_smp == ^word_w);
      wpar_q     <= ^out_data_i;
    end
    if (cmd_i.emit) begin
      level_q <= level_w;
      en_q    <= en_w;
      last_q  <= cmd_i.last;
      rdata_q <= (cmd_i.last && is_read_q) ? rd_word_q : '0;
      pok_q   <= cmd_i.last & is_read_q & with_par_q & ok_q;
    end
  end

  assign sts_o.timer_done = (tmr_q == '0);
  assign sts_o.is_read    = is_read_q;
  assign sts_o.with_par   = with_par_q;
  assign sts_o.cnt_zero   = (cnt_q == '0);
  assign sts_o.cnt_one    = (cnt_q == CNT_W'(1));

  assign swdio_level_o  = level_q;
  assign swdio_enable_o = en_q;
  assign read_data_o    = rdata_q;
  assign parity_ok_o    = pok_q;
  assign last_o         = last_q;

endmodule

// File: hdl/swd_ctrl.sv
// ----------------------------------------------------------------------------
// SWD controller
// Sequences turnaround, data and parity periods and tracks line direction.
// ----------------------------------------------------------------------------
module swd_ctrl
  import swd_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     req_valid_i,
  output logic     req_ready_o,
  input  logic     op_read_i,
  output logic     rsp_valid_o,
  input  logic     rsp_ready_i,
  input  swd_sts_t sts_i,
  output swd_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_TURN,
    S_DATA,
    S_PAR,
    S_TURNB
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   driving_q, driving_d;
  logic   slot_free, in_period;

  assign req_ready_o = (state_q == S_IDLE);
  assign slot_free   = ~out_valid_q | rsp_ready_i;
  assign in_period   = (state_q == S_TURN) || (state_q == S_DATA) ||
                       (state_q == S_PAR) || (state_q == S_TURNB);

  always_comb begin
    state_d     = state_q;
    driving_d   = driving_q;
    cmd_o.load  = req_valid_i & req_ready_o;
    cmd_o.emit  = in_period & sts_i.timer_done & slot_free;
    cmd_o.kind  = KIND_TURN;
    cmd_o.last  = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (cmd_o.load) begin
          state_d = S_LOAD;
        end
      end
      S_LOAD: begin
        if (sts_i.is_read == driving_q) begin
          state_d   = S_TURN;
          driving_d = ~sts_i.is_read;
        end else if (!sts_i.cnt_zero) begin
          state_d = S_DATA;
        end else if (sts_i.with_par) begin
          state_d = S_PAR;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_TURN: begin
        cmd_o.kind = KIND_TURN;
        cmd_o.last = sts_i.cnt_zero & ~sts_i.with_par;
        if (cmd_o.emit) begin
          if (!sts_i.cnt_zero) begin
            state_d = S_DATA;
          end else if (sts_i.with_par) begin
            state_d = S_PAR;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_DATA: begin
        cmd_o.kind = KIND_DATA;
        cmd_o.last = sts_i.cnt_one & ~sts_i.with_par;
        if (cmd_o.emit && sts_i.cnt_one) begin
          state_d = sts_i.with_par ? S_PAR : S_IDLE;
        end
      end
      S_PAR: begin
        cmd_o.kind = KIND_PAR;
        cmd_o.last = ~sts_i.is_read;
        if (cmd_o.emit) begin
          state_d = sts_i.is_read ? S_TURNB : S_IDLE;
        end
      end
      S_TURNB: begin
        cmd_o.kind = KIND_TURN;
        cmd_o.last = 1'b1;
        if (cmd_o.emit) begin
          state_d   = S_IDLE;
          driving_d = 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.emit) begin
      out_valid_d = 1'b1;
    end else if (rsp_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      driving_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      driving_q   <= driving_d;
    end
  end

  assign rsp_valid_o = out_valid_q;

  a_emit_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> (!out_valid_q || rsp_ready_i))
    else $error("period emitted over an untaken result");

  a_accept_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_i && req_ready_o) |=> (state_q == S_LOAD))
    else $error("accepted request not loaded");

  a_turnb_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_TURNB && cmd_o.emit) |=> (driving_q && state_q == S_IDLE))
    else $error("closing turnaround did not restore driving");

  a_read_floats: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DATA && sts_i.is_read) |-> !driving_q)
    else $error("read data period while line driven");

  a_load_read_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> (sts_i.is_read == $past(op_read_i)))
    else $error("request direction not captured");

endmodule

// File: hdl/swd_host_bit_engine.sv
// ----------------------------------------------------------------------------
// SWD host bit engine
// Flow: an accepted request passes the load state; each period then leaves
// once the period timer of the previous period has run out and the result
// slot is free. A request takes bit_count periods plus up to 3 periods of
// turnaround and parity, paced by the period timer and the single sequencer;
// one request at a time.
// Reset: asynchronous, active low; divider cleared to 0.
// ----------------------------------------------------------------------------
module swd_host_bit_engine
  import swd_pkg::*;
#(
  parameter int unsigned MAX_BITS = MAX_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  swd_req_if.sink          req_i,
  swd_rsp_if.source        rsp_o
);

  swd_cmd_t cmd;
  swd_sts_t sts;

  swd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .op_read_i   (req_i.op[OP_READ_BIT]),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  swd_dp #(
    .MaxBits (MAX_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .op_i           (req_i.op),
    .bit_count_i    (req_i.bit_count),
    .out_data_i     (req_i.out_data),
    .line_samples_i (req_i.line_samples),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .swdio_level_o  (rsp_o.swdio_level),
    .swdio_enable_o (rsp_o.swdio_enable),
    .read_data_o    (rsp_o.read_data),
    .parity_ok_o    (rsp_o.parity_ok),
    .last_o         (rsp_o.last)
  );

endmodule
